[rtl/core/jek_pkg.sv]
// Shared types and constants for the joystick event to key converter.
`default_nettype none
package jek_pkg;

    localparam int unsigned NUM_BUTTONS = 32;
    localparam int unsigned NUM_AXES    = 256;

    localparam int unsigned NUM_W       = 8;
    localparam int unsigned NUM_CMP_W   = NUM_W + 1;
    localparam int unsigned BTN_IDX_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int unsigned AXIS_ADDR_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    localparam int unsigned TYPE_W      = 8;
    localparam int unsigned VALUE_W     = 16;
    localparam int unsigned THRESH_W    = 15;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd500;

    localparam int unsigned TYPE_INIT_BIT   = 7;
    localparam int unsigned TYPE_BUTTON_BIT = 0;
    localparam int unsigned TYPE_AXIS_BIT   = 1;
    localparam logic [TYPE_W-2:0] TYPE_BUTTON = 7'd1;
    localparam logic [TYPE_W-2:0] TYPE_AXIS   = 7'd2;

    localparam logic signed [VALUE_W-1:0] VALUE_PRESSED = 16'sd1;

    localparam int unsigned STATUS_W = 2;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned POS_W    = 2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_NONE  = 2'd0,
        STATUS_KEY   = 2'd1,
        STATUS_ERROR = 2'd2
    } status_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_BUTTON = 2'd0,
        KIND_MINUS  = 2'd1,
        KIND_PLUS   = 2'd2
    } kind_t;

    typedef enum logic [POS_W-1:0] {
        POS_CENTRE = 2'd0,
        POS_MINUS  = 2'd1,
        POS_PLUS   = 2'd2
    } pos_t;

endpackage
`default_nettype wire

[rtl/core/jek_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module jek_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                             aclk,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  wire logic [WIDTH-1:0]                 wr_data,
    input  wire logic                             rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic      [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule
`default_nettype wire

[rtl/core/joystick_event_to_key_core.sv]
// Top level of the joystick event to key converter.
// Takes one raw joystick event per cycle unless a stalled output holds back the input,
// and returns exactly one result per event. When the output is free, the result register
// loads from the decision stage, so m_tvalid rises in the cycle after the event is
// taken. The accepting edge registers the event and reads the axis position RAM (one
// 2-bit entry per axis). The next edge takes the key event decision, updates button and
// axis state and loads the output register. The last axis write is forwarded so that
// events to the same axis in consecutive cycles see current state. A valid bit per axis
// makes a never-written axis read as centre, so no clearing pass follows reset. A
// stalled output holds one result while one more event waits in the decision stage. The
// user must write axis_threshold through cfg_wr_en and cfg_wr_data only while no event
// is in flight; the core itself does not enforce this.
`default_nettype none
module joystick_event_to_key_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [14:0] cfg_wr_data,   // axis_threshold
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,       // [7:0] event_number, [23:8] event_value
    input  wire logic [7:0]  s_tuser,       // [7:0] event_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,       // [7:0] key_number, [8] key_down, [15:9] zero
    output logic      [3:0]  m_tuser        // [1:0] status, [3:2] key_kind
);

    logic [jek_pkg::THRESH_W-1:0] thresh_reg;

    logic                                s1_valid_reg;
    logic [jek_pkg::TYPE_W-1:0]          s1_type_reg;
    logic [jek_pkg::NUM_W-1:0]           s1_num_reg;
    logic signed [jek_pkg::VALUE_W-1:0]  s1_value_reg;

    logic [jek_pkg::NUM_BUTTONS-1:0]     button_reg;
    logic [jek_pkg::NUM_BUTTONS-1:0]     button_next;
    logic [jek_pkg::NUM_AXES-1:0]        axis_valid_reg;

    logic                                fwd_valid_reg;
    logic [jek_pkg::AXIS_ADDR_W-1:0]     fwd_addr_reg;
    jek_pkg::pos_t                       fwd_pos_reg;

    logic                                m_valid_reg;
    jek_pkg::status_t                    m_status_reg;
    jek_pkg::kind_t                      m_kind_reg;
    logic [jek_pkg::NUM_W-1:0]           m_num_reg;
    logic                                m_down_reg;

    jek_pkg::status_t                    status_next;
    jek_pkg::kind_t                      kind_next;
    logic [jek_pkg::NUM_W-1:0]           num_next;
    logic                                down_next;
    logic                                button_wr;
    logic                                axis_wr;

    logic                                s_accept;
    logic                                s1_advance;
    logic [jek_pkg::POS_W-1:0]           ram_rd_data;
    logic [jek_pkg::AXIS_ADDR_W-1:0]     s1_axis_addr;
    logic [jek_pkg::BTN_IDX_W-1:0]       s1_btn_idx;
    logic [jek_pkg::NUM_CMP_W-1:0]       s1_num_ext;
    logic [jek_pkg::TYPE_W-2:0]          s1_stype;
    logic                                s1_init;
    jek_pkg::pos_t                       old_pos;
    jek_pkg::pos_t                       new_pos;
    logic signed [jek_pkg::VALUE_W:0]    value_ext;
    logic signed [jek_pkg::VALUE_W:0]    thresh_pos;
    logic signed [jek_pkg::VALUE_W:0]    thresh_neg;
    logic                                btn_now;
    logic                                btn_was;

    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign s_accept   = s_tvalid && s_tready;

    assign s1_axis_addr = s1_num_reg[jek_pkg::AXIS_ADDR_W-1:0];
    assign s1_btn_idx   = s1_num_reg[jek_pkg::BTN_IDX_W-1:0];
    assign s1_num_ext   = {1'b0, s1_num_reg};
    assign s1_stype     = s1_type_reg[jek_pkg::TYPE_W-2:0];
    assign s1_init      = s1_type_reg[jek_pkg::TYPE_INIT_BIT];

    jek_ram #(
        .WIDTH(jek_pkg::POS_W),
        .DEPTH(jek_pkg::NUM_AXES)
    ) u_axis_ram (
        .aclk    (aclk),
        .wr_en   (axis_wr),
        .wr_addr (s1_axis_addr),
        .wr_data (new_pos),
        .rd_en   (s_accept),
        .rd_addr (s_tdata[jek_pkg::AXIS_ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        value_ext  = {s1_value_reg[jek_pkg::VALUE_W-1], s1_value_reg};
        thresh_pos = {2'b00, thresh_reg};
        thresh_neg = -thresh_pos;
        if (value_ext < thresh_neg) begin
            new_pos = jek_pkg::POS_MINUS;
        end else if (value_ext > thresh_pos) begin
            new_pos = jek_pkg::POS_PLUS;
        end else begin
            new_pos = jek_pkg::POS_CENTRE;
        end

        if (fwd_valid_reg && (fwd_addr_reg == s1_axis_addr)) begin
            old_pos = fwd_pos_reg;
        end else if (axis_valid_reg[s1_axis_addr]) begin
            old_pos = jek_pkg::pos_t'(ram_rd_data);
        end else begin
            old_pos = jek_pkg::POS_CENTRE;
        end
    end

    always_comb begin
        btn_now     = (s1_value_reg == jek_pkg::VALUE_PRESSED);
        btn_was     = button_reg[s1_btn_idx];
        status_next = jek_pkg::STATUS_NONE;
        kind_next   = jek_pkg::KIND_BUTTON;
        num_next    = '0;
        down_next   = 1'b0;
        button_wr   = 1'b0;
        axis_wr     = 1'b0;
        if (s1_stype[jek_pkg::TYPE_BUTTON_BIT]) begin
            if (s1_num_ext >= jek_pkg::NUM_CMP_W'(jek_pkg::NUM_BUTTONS)) begin
                status_next = jek_pkg::STATUS_ERROR;
            end else if (!(s1_init && (s1_stype == jek_pkg::TYPE_BUTTON)
                           && (btn_now == btn_was))) begin
                status_next = jek_pkg::STATUS_KEY;
                num_next    = s1_num_reg;
                down_next   = btn_now;
                button_wr   = s1_advance;
            end
        end else if (s1_stype[jek_pkg::TYPE_AXIS_BIT]) begin
            if ((s1_num_ext < jek_pkg::NUM_CMP_W'(jek_pkg::NUM_AXES)) && (new_pos != old_pos)) begin
                status_next = jek_pkg::STATUS_KEY;
                num_next    = s1_num_reg;
                axis_wr     = s1_advance;
                unique case (new_pos)
                    jek_pkg::POS_MINUS: begin
                        kind_next = jek_pkg::KIND_MINUS;
                        down_next = 1'b1;
                    end
                    jek_pkg::POS_PLUS: begin
                        kind_next = jek_pkg::KIND_PLUS;
                        down_next = 1'b1;
                    end
                    default: begin
                        kind_next = (old_pos == jek_pkg::POS_PLUS) ?
                                    jek_pkg::KIND_PLUS : jek_pkg::KIND_MINUS;
                        down_next = 1'b0;
                    end
                endcase
            end
        end else begin
            status_next = jek_pkg::STATUS_ERROR;
        end
    end

    always_comb begin
        button_next = button_reg;
        if (button_wr) begin
            button_next[s1_btn_idx] = btn_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg     <= jek_pkg::THRESH_RESET;
            s1_valid_reg   <= 1'b0;
            button_reg     <= '0;
            axis_valid_reg <= '0;
            fwd_valid_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                thresh_reg <= cfg_wr_data;
            end
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_advance) begin
                s1_valid_reg <= 1'b0;
            end
            button_reg <= button_next;
            if (axis_wr) begin
                axis_valid_reg[s1_axis_addr] <= 1'b1;
                fwd_valid_reg                <= 1'b1;
            end
            if (s1_advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_type_reg  <= s_tuser;
            s1_num_reg   <= s_tdata[7:0];
            s1_value_reg <= s_tdata[23:8];
        end
        if (axis_wr) begin
            fwd_addr_reg <= s1_axis_addr;
            fwd_pos_reg  <= new_pos;
        end
        if (s1_advance) begin
            m_status_reg <= status_next;
            m_kind_reg   <= kind_next;
            m_num_reg    <= num_next;
            m_down_reg   <= down_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_down_reg, m_num_reg};
    assign m_tuser  = {m_kind_reg, m_status_reg};

    a_no_key_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != jek_pkg::STATUS_KEY)) |->
        ((m_num_reg == '0) && !m_down_reg && (m_kind_reg == jek_pkg::KIND_BUTTON)))
        else $error("non-key result carries key fields");

    a_axis_valid_set: assert property (@(posedge aclk) disable iff (!aresetn)
        axis_wr |=> axis_valid_reg[$past(s1_axis_addr)])
        else $error("axis write did not mark entry valid");

    a_fwd_tracks_write: assert property (@(posedge aclk) disable iff (!aresetn)
        axis_wr |=> (fwd_valid_reg && (fwd_addr_reg == $past(s1_axis_addr))
                     && (fwd_pos_reg == $past(new_pos))))
        else $error("forward register lost the last axis write");

    a_state_only_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s1_advance) |=> (button_reg == $past(button_reg)))
        else $error("button state changed without an advancing transaction");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while decision stage is stalled");

endmodule
`default_nettype wire

[bench/jek_bench_pkg.sv]
// Event codes and the key event scoreboard for the joystick event to key bench.
package jek_bench_pkg;
    import jek_pkg::*;

    localparam logic [TYPE_W-1:0] EV_NONE   = 8'h00;
    localparam logic [TYPE_W-1:0] EV_BUTTON = 8'h01;
    localparam logic [TYPE_W-1:0] EV_AXIS   = 8'h02;
    localparam logic [TYPE_W-1:0] EV_BOTH   = 8'h03;
    localparam logic [TYPE_W-1:0] EV_INIT   = 8'h80;

    typedef struct packed {
        status_t          status;
        kind_t            kind;
        logic [NUM_W-1:0] number;
        logic             down;
    } key_event_t;

    class key_tracker;
        logic [THRESH_W-1:0]    threshold;
        logic [NUM_BUTTONS-1:0] pressed;
        pos_t                   axis_pos [NUM_AXES];
        key_event_t             expected_keys [$];
        int                     errors;

        function new();
            threshold = THRESH_RESET;
            pressed   = '0;
            foreach (axis_pos[i]) axis_pos[i] = POS_CENTRE;
            errors    = 0;
        endfunction

        function void set_threshold(logic [THRESH_W-1:0] t);
            threshold = t;
        endfunction

        function pos_t zone(logic signed [VALUE_W-1:0] v);
            int pos_v;
            int t;
            pos_v = v;
            t     = int'(threshold);
            if (pos_v < -t) return POS_MINUS;
            if (pos_v > t) return POS_PLUS;
            return POS_CENTRE;
        endfunction

        function void note_event(logic [TYPE_W-1:0] ev_type, logic [NUM_W-1:0] ev_num,
                                 logic signed [VALUE_W-1:0] ev_value);
            logic              init_flag;
            logic [TYPE_W-2:0] kind_bits;
            logic              now_down;
            logic              was_down;
            pos_t              old_pos;
            pos_t              new_pos;
            key_event_t        res;
            init_flag = ev_type[TYPE_INIT_BIT];
            kind_bits = ev_type[TYPE_W-2:0];
            res       = '{STATUS_NONE, KIND_BUTTON, '0, 1'b0};
            if (kind_bits[TYPE_BUTTON_BIT]) begin
                if (ev_num >= NUM_BUTTONS) begin
                    res.status = STATUS_ERROR;
                end else begin
                    now_down = (ev_value == VALUE_PRESSED);
                    was_down = pressed[ev_num[BTN_IDX_W-1:0]];
                    if (!(init_flag && kind_bits == TYPE_BUTTON && now_down == was_down)) begin
                        pressed[ev_num[BTN_IDX_W-1:0]] = now_down;
                        res.status = STATUS_KEY;
                        res.number = ev_num;
                        res.down   = now_down;
                    end
                end
            end else if (kind_bits[TYPE_AXIS_BIT]) begin
                if (ev_num < NUM_AXES) begin
                    old_pos = axis_pos[ev_num];
                    new_pos = zone(ev_value);
                    if (new_pos != old_pos) begin
                        axis_pos[ev_num] = new_pos;
                        res.status = STATUS_KEY;
                        res.number = ev_num;
                        if (new_pos == POS_MINUS) begin
                            res.kind = KIND_MINUS;
                            res.down = 1'b1;
                        end else if (new_pos == POS_PLUS) begin
                            res.kind = KIND_PLUS;
                            res.down = 1'b1;
                        end else begin
                            res.kind = (old_pos == POS_PLUS) ? KIND_PLUS : KIND_MINUS;
                        end
                    end
                end
            end else begin
                res.status = STATUS_ERROR;
            end
            expected_keys.push_back(res);
        endfunction

        function void check_key(logic [STATUS_W-1:0] st, logic [KIND_W-1:0] kd,
                                logic [NUM_W-1:0] num, logic down, logic [6:0] pad);
            key_event_t exp_key;
            if (expected_keys.size() == 0) begin
                $error("unexpected key result: status %0d number %0d", st, num);
                errors++;
                return;
            end
            exp_key = expected_keys.pop_front();
            if (st !== exp_key.status) begin
                $error("status: expected %0d, got %0d", exp_key.status, st);
                errors++;
            end
            if (kd !== exp_key.kind) begin
                $error("key_kind: expected %0d, got %0d", exp_key.kind, kd);
                errors++;
            end
            if (num !== exp_key.number) begin
                $error("key_number: expected %0d, got %0d", exp_key.number, num);
                errors++;
            end
            if (down !== exp_key.down) begin
                $error("key_down: expected %0d, got %0d", exp_key.down, down);
                errors++;
            end
            if (pad !== '0) begin
                $error("m_tdata pad: expected 0, got %0h", pad);
                errors++;
            end
        endfunction

        function int pending();
            return expected_keys.size();
        endfunction
    endclass

endpackage

[bench/tb.sv]
// Top-level bench for joystick_event_to_key_core: random and directed events, scoreboard.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import jek_pkg::*;
    import jek_bench_pkg::*;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int NUM_PHASES       = 6;
    localparam int RANDOM_PER_PHASE = 212;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [14:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata     = '0;
    logic [7:0]  s_tuser     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;
    logic [3:0]  m_tuser;

    key_tracker keys = new();
    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    int rx_hold      = 0;
    int idle_cycles  = 0;

    joystick_event_to_key_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #2 aclk = ~aclk;

    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
            rx_hold = $urandom_range(1, 15) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            keys.check_key(m_tuser[1:0], m_tuser[3:2], m_tdata[7:0], m_tdata[8], m_tdata[15:9]);
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("tb: errors");
        $finish;
    end

    task automatic send_event(logic [7:0] ev_type, logic [7:0] ev_num, logic signed [15:0] ev_value);
        s_tvalid <= 1'b1;
        s_tuser  <= ev_type;
        s_tdata  <= {ev_value, ev_num};
        do @(posedge aclk); while (!s_tready);
        keys.note_event(ev_type, ev_num, ev_value);
        @(negedge aclk);
        if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (keys.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_threshold(logic [14:0] t);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= t;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        keys.set_threshold(t);
    endtask

    function automatic logic signed [15:0] axis_value();
        int t;
        int v;
        t = int'(keys.threshold);
        case ($urandom_range(0, 7))
            0: v = t + 1;
            1: v = t;
            2: v = -t;
            3: v = -t - 1;
            4: v = -32768;
            5: v = 32767;
            6: v = 0;
            default: v = $signed(16'($urandom));
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    task automatic random_event();
        int          pick;
        logic [7:0]  ev_type;
        logic [7:0]  ev_num;
        logic [15:0] ev_value;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            ev_type  = EV_AXIS | (($urandom_range(0, 4) == 0) ? EV_INIT : EV_NONE);
            ev_num   = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
            ev_value = axis_value();
        end else if (pick < 80) begin
            ev_type = EV_BUTTON | (($urandom_range(0, 4) == 0) ? EV_INIT : EV_NONE);
            ev_num  = ($urandom_range(0, 6) != 0) ? 8'($urandom_range(0, NUM_BUTTONS - 1))
                                                  : 8'($urandom);
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8: ev_value = VALUE_PRESSED;
                9, 10, 11, 12, 13, 14, 15: ev_value = '0;
                default: ev_value = 16'($urandom);
            endcase
        end else if (pick < 88) begin
            ev_type  = EV_BOTH | (($urandom_range(0, 1) == 0) ? EV_INIT : EV_NONE);
            ev_num   = 8'($urandom_range(0, 40));
            ev_value = $urandom_range(0, 1) ? 16'(VALUE_PRESSED) : 16'($urandom);
        end else begin
            ev_type  = 8'($urandom);
            ev_num   = 8'($urandom);
            ev_value = 16'($urandom);
        end
        send_event(ev_type, ev_num, ev_value);
    endtask

    initial begin
        logic [14:0] t;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        tx_gap_pct   = 30;
        rx_stall_pct = 10;
        send_event(EV_BUTTON, 8'd0, 16'sd1);
        send_event(EV_BUTTON | EV_INIT, 8'd0, 16'sd1);
        send_event(EV_BUTTON | EV_INIT, 8'd0, 16'sd0);
        send_event(EV_BUTTON, 8'd31, 16'sd32767);
        send_event(EV_BUTTON, 8'd31, 16'sd1);
        send_event(EV_BUTTON, 8'd31, -16'sd32768);
        send_event(EV_BUTTON, 8'd32, 16'sd1);
        send_event(EV_BUTTON | EV_INIT, 8'd255, 16'sd1);
        send_event(EV_BOTH, 8'd5, 16'sd1);
        send_event(EV_BOTH | EV_INIT, 8'd5, 16'sd1);
        send_event(EV_NONE, 8'd3, 16'sd1);
        send_event(EV_INIT, 8'd3, 16'sd1);
        send_event(8'h7C, 8'd3, 16'sd1);
        send_event(8'hFF, 8'd31, 16'sd0);
        send_event(EV_AXIS, 8'd0, 16'sd501);
        send_event(EV_AXIS, 8'd0, 16'sd500);
        send_event(EV_AXIS, 8'd0, -16'sd501);
        send_event(EV_AXIS | EV_INIT, 8'd0, -16'sd32768);
        send_event(EV_AXIS, 8'd0, -16'sd500);
        send_event(EV_AXIS, 8'd255, 16'sd32767);
        send_event(EV_AXIS | EV_INIT, 8'd255, 16'sd0);
        send_event(EV_AXIS, 8'd255, -16'sd32768);
        send_event(EV_AXIS, 8'd255, 16'sd32767);
        send_event(EV_AXIS, 8'd255, 16'sd32766);
        send_event(EV_AXIS | EV_INIT, 8'd7, 16'sd0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: t = '0;
                1: t = 15'h7FFF;
                2: t = 15'd1;
                3: t = 15'($urandom);
                4: t = THRESH_RESET;
                default: t = 15'($urandom_range(0, 2000));
            endcase
            write_threshold(t);
            if (p == NUM_PHASES - 1) begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end else begin
                tx_gap_pct   = (p % 2) ? 20 : 5;
                rx_stall_pct = (p == 2) ? 0 : 15;
            end
            for (int i = 0; i < RANDOM_PER_PHASE; i++) random_event();
        end

        drain();
        repeat (8) @(posedge aclk);
        if (keys.errors == 0 && keys.pending() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/jek_pkg.sv
rtl/core/jek_ram.sv
rtl/core/joystick_event_to_key_core.sv
bench/jek_bench_pkg.sv
bench/tb.sv
